// File: hw/rtl/aes256ke_pkg.sv
// ----------------------------------------------------------------------------
// aes256ke_pkg
// Types and constants for the AES-256 key expansion block: beat structs,
// the AES S-box and the round constants.
// ----------------------------------------------------------------------------
package aes256ke_pkg;

	localparam int unsigned KEY_WORDS   = 8;
	localparam int unsigned SCHED_WORDS = 60;
	localparam int unsigned ROUND_KEYS  = SCHED_WORDS / 4;
	localparam int unsigned RND_W       = 4;

	localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_KEYS - 1);

	typedef struct packed {
		logic [63:0] key_part_0;
		logic [63:0] key_part_1;
		logic [63:0] key_part_2;
		logic [63:0] key_part_3;
	} key_beat_t;

	typedef struct packed {
		logic [RND_W-1:0] round_index;
		logic [63:0]      round_key_high;
		logic [63:0]      round_key_low;
		logic             last_round;
	} round_beat_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Rcon for schedule words 8, 16, ..., first byte only
	localparam logic [7:0] RCON [8] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
	};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

// File: hw/rtl/aes256_key_expansion.sv
// ----------------------------------------------------------------------------
// aes256_key_expansion
// AES-256 key schedule: takes one 256-bit key, emits the 15 round keys in
// order, one round key per output beat.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+--------------------------
//  key      | in        | key_valid / key_stall    | key_beat   (key_beat_t)
//  round    | out       | round_valid / round_stall| round_beat (round_beat_t)
//
//  Per key: the key beat, then 15 round key beats at one per cycle while the
//  output channel does not stall; the single SubWord unit builds four schedule
//  words per step from an eight-word window.
//  key_stall is high from the key beat until the round 14 beat is taken.
//  Output stalls hold the current round key and freeze the schedule.
//  Reset clears the sequencer only; the window holds no reset value.
// ----------------------------------------------------------------------------
module aes256_key_expansion
	import aes256ke_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        key_valid,
	output logic        key_stall,
	input  key_beat_t   key_beat,
	output logic        round_valid,
	input  logic        round_stall,
	output round_beat_t round_beat
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t           state_q;
	logic [RND_W-1:0] rnd_q;
	logic [31:0]      win_q [KEY_WORDS];

	logic        key_acc;
	logic        rk_acc;
	logic        last_rnd;
	logic        odd_step;
	logic [31:0] sub_in;
	logic [31:0] sub_out;
	logic [31:0] tmp;
	logic [31:0] nw [4];

	assign key_acc  = key_valid & ~key_stall;
	assign rk_acc   = round_valid & ~round_stall;
	assign last_rnd = (rnd_q == LAST_ROUND);

	// Window holds words 4r..4r+7; new words 4r+8.. start at mod 8 of 0 or 4
	assign odd_step = rnd_q[0];
	assign sub_in   = odd_step ? win_q[7] : {win_q[7][23:0], win_q[7][31:24]};
	assign sub_out  = sub_word(sub_in);
	assign tmp      = odd_step ? sub_out : (sub_out ^ {RCON[rnd_q[3:1]], 24'h0});

	always_comb begin
		nw[0] = win_q[0] ^ tmp;
		nw[1] = win_q[1] ^ nw[0];
		nw[2] = win_q[2] ^ nw[1];
		nw[3] = win_q[3] ^ nw[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (key_acc) begin
						state_q <= ST_RUN;
						rnd_q   <= '0;
					end
				end
				ST_RUN: begin
					if (rk_acc) begin
						if (last_rnd) begin
							state_q <= ST_IDLE;
						end else begin
							rnd_q <= rnd_q + RND_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (key_acc) begin
			win_q[0] <= key_beat.key_part_0[63:32];
			win_q[1] <= key_beat.key_part_0[31:0];
			win_q[2] <= key_beat.key_part_1[63:32];
			win_q[3] <= key_beat.key_part_1[31:0];
			win_q[4] <= key_beat.key_part_2[63:32];
			win_q[5] <= key_beat.key_part_2[31:0];
			win_q[6] <= key_beat.key_part_3[63:32];
			win_q[7] <= key_beat.key_part_3[31:0];
		end else if (rk_acc && !last_rnd) begin
			win_q[0] <= win_q[4];
			win_q[1] <= win_q[5];
			win_q[2] <= win_q[6];
			win_q[3] <= win_q[7];
			win_q[4] <= nw[0];
			win_q[5] <= nw[1];
			win_q[6] <= nw[2];
			win_q[7] <= nw[3];
		end
	end

	assign key_stall   = (state_q != ST_IDLE);
	assign round_valid = (state_q == ST_RUN);

	always_comb begin
		round_beat.round_index    = rnd_q;
		round_beat.round_key_high = {win_q[0], win_q[1]};
		round_beat.round_key_low  = {win_q[2], win_q[3]};
		round_beat.last_round     = last_rnd;
	end

endmodule

// File: hw/rtl/aes256ke_checker.sv
// ----------------------------------------------------------------------------
// aes256ke_checker
// Port-level checks for the AES-256 key expansion block, bound to the top.
// ----------------------------------------------------------------------------
module aes256ke_checker
	import aes256ke_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        key_valid,
	input logic        key_stall,
	input logic        round_valid,
	input logic        round_stall,
	input round_beat_t round_beat
);

	// stalled round beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		round_valid && round_stall |=> round_valid && $stable(round_beat))
		else $error("round beat changed under stall");

	// a key starts a run at round 0
	a_first_round: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && !key_stall |=> round_valid && round_beat.round_index == '0)
		else $error("run did not start at round 0");

	// rounds step by one until the last
	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		round_valid && !round_stall && !round_beat.last_round |=>
		round_valid &&
		round_beat.round_index == $past(round_beat.round_index) + RND_W'(1))
		else $error("round index skipped");

	// last flag only on the final round key
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		round_valid && round_beat.last_round |-> round_beat.round_index == LAST_ROUND)
		else $error("last flag on wrong round");

	// after the last beat the block takes a new key
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		round_valid && !round_stall && round_beat.last_round |=>
		!key_stall && !round_valid)
		else $error("block busy after last round");

endmodule

bind aes256_key_expansion aes256ke_checker u_aes256ke_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.key_valid   (key_valid),
	.key_stall   (key_stall),
	.round_valid (round_valid),
	.round_stall (round_stall),
	.round_beat  (round_beat)
);

// File: sim/aes256_key_expansion_test.sv
// ----------------------------------------------------------------------------
// aes256_key_expansion_test
// Self-checking bench for the AES-256 key schedule. Each 256-bit key beat is
// expanded by an independent in-bench schedule with its own S-box, derived
// from GF(2^8) inversion and the affine map. Every round key beat is then
// checked field by field, in order. The run passes through several
// source-idle and sink-stall mixes.
// ----------------------------------------------------------------------------
module aes256_key_expansion_test
	import aes256ke_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        key_valid   = 1'b0;
	logic        key_stall;
	key_beat_t   key_beat    = '0;
	logic        round_valid;
	logic        round_stall = 1'b0;
	round_beat_t round_beat;

	key_beat_t   keys_pending[$];
	round_beat_t rk_due[$];
	logic [7:0]  sbox_lut[256];

	int send_idle_pct   = 0;
	int stall_pct       = 0;
	int mismatches      = 0;
	int keys_taken      = 0;
	int rk_seen         = 0;

	aes256_key_expansion u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_valid   (key_valid),
		.key_stall   (key_stall),
		.key_beat    (key_beat),
		.round_valid (round_valid),
		.round_stall (round_stall),
		.round_beat  (round_beat)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = xtime(a);
		end
		return p;
	endfunction

	function automatic logic [31:0] sub_bytes(input logic [31:0] w);
		return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
	endfunction

	// full 60-word schedule, queued as 15 round key beats
	function automatic void expand_key(input key_beat_t k);
		logic [31:0] w[SCHED_WORDS];
		logic [31:0] t;
		logic [7:0]  rc;
		round_beat_t rk;
		{w[0], w[1]} = k.key_part_0;
		{w[2], w[3]} = k.key_part_1;
		{w[4], w[5]} = k.key_part_2;
		{w[6], w[7]} = k.key_part_3;
		rc = 8'h01;
		for (int i = KEY_WORDS; i < SCHED_WORDS; i++) begin
			t = w[i-1];
			if (i % KEY_WORDS == 0) begin
				t = sub_bytes({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = xtime(rc);
			end else if (i % KEY_WORDS == 4) begin
				t = sub_bytes(t);
			end
			w[i] = w[i-KEY_WORDS] ^ t;
		end
		for (int r = 0; r < ROUND_KEYS; r++) begin
			rk.round_index    = RND_W'(r);
			rk.round_key_high = {w[4*r], w[4*r+1]};
			rk.round_key_low  = {w[4*r+2], w[4*r+3]};
			rk.last_round     = (rk.round_index == LAST_ROUND);
			rk_due.push_back(rk);
		end
	endfunction

	function automatic key_beat_t random_key();
		key_beat_t k;
		logic [7:0] b;
		case ($urandom_range(9))
			0: begin
				k = '0;
				k[$urandom_range(255)] = 1'b1;
			end
			1: begin
				b = 8'($urandom);
				k = {32{b}};
			end
			default: k = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
		endcase
		return k;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// source: present queued keys, idle at random between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid <= 1'b0;
		end else if (!key_valid || !key_stall) begin
			if (keys_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				key_beat  <= keys_pending.pop_front();
				key_valid <= 1'b1;
			end else begin
				key_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			round_stall <= 1'b0;
		else
			round_stall <= ($urandom_range(99) < stall_pct);
	end

	// predict on the key beat first, then check the round beat of this edge
	always @(posedge clk) begin
		round_beat_t exp_rk;
		if (arst_n) begin
			if (key_valid && !key_stall) begin
				expand_key(key_beat);
				keys_taken++;
			end
			if (round_valid && !round_stall) begin
				rk_seen++;
				if (rk_due.size() == 0) begin
					report_mismatch($sformatf("unexpected round beat, round %0d",
						round_beat.round_index));
				end else begin
					exp_rk = rk_due.pop_front();
					if (round_beat.round_index !== exp_rk.round_index)
						report_mismatch($sformatf("round_index %0d, want %0d",
							round_beat.round_index, exp_rk.round_index));
					if (round_beat.round_key_high !== exp_rk.round_key_high)
						report_mismatch($sformatf("round %0d high %h, want %h",
							exp_rk.round_index, round_beat.round_key_high,
							exp_rk.round_key_high));
					if (round_beat.round_key_low !== exp_rk.round_key_low)
						report_mismatch($sformatf("round %0d low %h, want %h",
							exp_rk.round_index, round_beat.round_key_low,
							exp_rk.round_key_low));
					if (round_beat.last_round !== exp_rk.last_round)
						report_mismatch($sformatf("round %0d last_round %b, want %b",
							exp_rk.round_index, round_beat.last_round,
							exp_rk.last_round));
				end
			end
		end
	end

	// queue n random keys under one idle/stall mix, then drain completely
	task automatic run_phase(input int n_keys, input int idle, input int stall);
		@(negedge clk);
		send_idle_pct = idle;
		stall_pct     = stall;
		for (int i = 0; i < n_keys; i++)
			keys_pending.push_back(random_key());
		while (keys_pending.size() != 0 || key_valid || rk_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [7:0] inv;
		logic [7:0] r;
		logic [7:0] s;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			if (x != 0) begin
				inv = 8'h01;
				repeat (254) inv = gf_mul(inv, 8'(x));
			end
			r = inv;
			s = inv;
			for (int n = 0; n < 4; n++) begin
				r = {r[6:0], r[7]};
				s ^= r;
			end
			sbox_lut[x] = s ^ 8'h63;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		keys_pending.push_back('0);
		keys_pending.push_back('1);
		keys_pending.push_back({64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f});
		keys_pending.push_back({64'h603deb1015ca71be, 64'h2b73aef0857d7781,
			64'h1f352c073b6108d7, 64'h2d9810a30914dff4});
		keys_pending.push_back({32{8'h55}});
		keys_pending.push_back({32{8'haa}});
		keys_pending.push_back({1'b1, 255'b0});
		keys_pending.push_back({255'b0, 1'b1});
		keys_pending.push_back({64'hffffffffffffffff, 192'b0});
		keys_pending.push_back({64'b0, 64'hffffffffffffffff, 128'b0});
		keys_pending.push_back({128'b0, 64'hffffffffffffffff, 64'b0});
		keys_pending.push_back({192'b0, 64'hffffffffffffffff});
		keys_pending.push_back({64'hfffefdfcfbfaf9f8, 64'hf7f6f5f4f3f2f1f0,
			64'hefeeedecebeae9e8, 64'he7e6e5e4e3e2e1e0});
		run_phase(0, 0, 0);

		// each phase drains fully, so the source also sits out whole schedules
		run_phase(50, 0, 0);
		run_phase(50, 66, 0);
		run_phase(50, 0, 66);
		run_phase(50, 16, 16);

		repeat (20) @(posedge clk);
		if (rk_due.size() != 0)
			report_mismatch($sformatf("%0d round keys never arrived", rk_due.size()));

		$display("expanded %0d keys, checked %0d round key beats", keys_taken, rk_seen);
		$display("mixes: free flow, source idle, sink stall, both; %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("aes256_key_expansion_test: clean");
		else
			$display("aes256_key_expansion_test: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d round keys outstanding", rk_due.size());
		$display("aes256_key_expansion_test: errors");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/aes256ke_pkg.sv
hw/rtl/aes256_key_expansion.sv
hw/rtl/aes256ke_checker.sv
sim/aes256_key_expansion_test.sv
